// ===== design/fdct_pkg.sv =====
// ----------------------------------------------------------------------------
// fdct_pkg
// Shared types and codes for the fan duty curve tracker: fan modes,
// register indexes, tracker direction, config and tracker status bundles.
// ----------------------------------------------------------------------------
package fdct_pkg;

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_DISABLED = 3'd1,
    MODE_QUIET    = 3'd2,
    MODE_SPORT    = 3'd3,
    MODE_CUSTOM   = 3'd4,
    MODE_SMART    = 3'd5
  } fdct_mode_t;

  typedef enum logic [2:0] {
    CFG_SAFE_MAX_DUTY   = 3'd0,
    CFG_MIN_TEMP        = 3'd1,
    CFG_MAX_TEMP        = 3'd2,
    CFG_HIGH_TEMP       = 3'd3,
    CFG_HYSTERESIS_DEG  = 3'd4,
    CFG_DEBOUNCE_COUNT  = 3'd5,
    CFG_CUSTOM_MIN_DUTY = 3'd6,
    CFG_CUSTOM_MAX_DUTY = 3'd7
  } fdct_cfg_idx_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } fdct_dir_t;

  typedef struct packed {
    logic        [15:0] safe_max_duty;
    logic signed [8:0]  min_temp;
    logic signed [8:0]  max_temp;
    logic signed [8:0]  high_temp;
    logic        [7:0]  hysteresis_deg;
    logic        [3:0]  debounce_count;
    logic        [15:0] custom_min_duty;
    logic        [15:0] custom_max_duty;
  } fdct_cfg_t;

  typedef struct packed {
    logic        valid;
    logic        changed;
    logic [15:0] duty;
  } fdct_track_t;

endpackage

// ===== design/fdct_curve.sv =====
// ----------------------------------------------------------------------------
// fdct_curve
// Quiet and sport curve lookup. Fixed segments are base plus slope times
// offset; the tail segment toward safe max uses quotient and remainder of the
// span, registered and refreshed in the cycle after the safe max register changes.
// ----------------------------------------------------------------------------
module fdct_curve (
  input  logic               clk,
  input  logic [15:0]        safe_max_duty,
  input  logic               is_sport,
  input  logic signed [8:0]  temperature,
  output logic [15:0]        duty
);

  localparam logic [15:0] QUIET_TAIL_BASE = 16'd22000;
  localparam logic [15:0] SPORT_TAIL_BASE = 16'd21000;
  localparam logic [15:0] RECIP_5_10      = 16'd52429;

  logic        tq_neg_nxt, ts_neg_nxt;
  logic [15:0] tq_mag, ts_mag;
  logic [31:0] tq_prod, ts_prod;
  logic [13:0] tq_quo_nxt;
  logic [12:0] ts_quo_nxt;
  logic [15:0] tq_quo_x5, ts_quo_x10;
  logic [2:0]  tq_rem_nxt;
  logic [3:0]  ts_rem_nxt;

  logic        tq_neg_r, ts_neg_r;
  logic [13:0] tq_quo_r;
  logic [12:0] ts_quo_r;
  logic [2:0]  tq_rem_r;
  logic [3:0]  ts_rem_r;

  // span of the tail segment, split by its width (5 for quiet, 10 for sport)
  always_comb begin
    tq_neg_nxt = safe_max_duty < QUIET_TAIL_BASE;
    ts_neg_nxt = safe_max_duty < SPORT_TAIL_BASE;
    tq_mag     = tq_neg_nxt ? QUIET_TAIL_BASE - safe_max_duty
                            : safe_max_duty - QUIET_TAIL_BASE;
    ts_mag     = ts_neg_nxt ? SPORT_TAIL_BASE - safe_max_duty
                            : safe_max_duty - SPORT_TAIL_BASE;
    tq_prod    = 32'(tq_mag) * 32'(RECIP_5_10);
    ts_prod    = 32'(ts_mag) * 32'(RECIP_5_10);
    tq_quo_nxt = tq_prod[31:18];
    ts_quo_nxt = ts_prod[31:19];
    tq_quo_x5  = {tq_quo_nxt, 2'b00} + {2'b00, tq_quo_nxt};
    ts_quo_x10 = {ts_quo_nxt, 3'b000} + {2'b00, ts_quo_nxt, 1'b0};
    tq_rem_nxt = 3'(tq_mag - tq_quo_x5);
    ts_rem_nxt = 4'(ts_mag - ts_quo_x10);
  end

  always_ff @(posedge clk) begin
    tq_neg_r <= tq_neg_nxt;
    tq_quo_r <= tq_quo_nxt;
    tq_rem_r <= tq_rem_nxt;
    ts_neg_r <= ts_neg_nxt;
    ts_quo_r <= ts_quo_nxt;
    ts_rem_r <= ts_rem_nxt;
  end

  logic [15:0]        seg_base;
  logic [8:0]         seg_slope;
  logic [3:0]         seg_dt;
  logic               seg_tail;
  logic               seg_top;
  logic [16:0]        fixed_val;
  logic [17:0]        tail_whole;
  logic [6:0]         tail_rd;
  logic [15:0]        tail_frac_prod;
  logic [6:0]         tail_frac;
  logic [17:0]        tail_mag;
  logic               tail_neg;
  logic [15:0]        tail_base;
  logic signed [19:0] tail_val;
  logic signed [19:0] raw;

  always_comb begin
    seg_base  = '0;
    seg_slope = '0;
    seg_dt    = '0;
    seg_tail  = 1'b0;
    seg_top   = 1'b0;
    if (!is_sport) begin
      if (temperature <= 9'sd40) begin
        seg_base = 16'd5000;
      end else if (temperature <= 9'sd50) begin
        seg_base  = 16'd5000;
        seg_slope = 9'd300;
        seg_dt    = 4'(temperature - 9'sd40);
      end else if (temperature <= 9'sd60) begin
        seg_base  = 16'd8000;
        seg_slope = 9'd400;
        seg_dt    = 4'(temperature - 9'sd50);
      end else if (temperature <= 9'sd70) begin
        seg_base  = 16'd12000;
        seg_slope = 9'd500;
        seg_dt    = 4'(temperature - 9'sd60);
      end else if (temperature <= 9'sd80) begin
        seg_base  = 16'd17000;
        seg_slope = 9'd500;
        seg_dt    = 4'(temperature - 9'sd70);
      end else if (temperature <= 9'sd85) begin
        seg_tail = 1'b1;
        seg_dt   = 4'(temperature - 9'sd80);
      end else begin
        seg_top = 1'b1;
      end
    end else begin
      if (temperature <= 9'sd35) begin
        seg_base = 16'd8000;
      end else if (temperature <= 9'sd45) begin
        seg_base  = 16'd8000;
        seg_slope = 9'd400;
        seg_dt    = 4'(temperature - 9'sd35);
      end else if (temperature <= 9'sd55) begin
        seg_base  = 16'd12000;
        seg_slope = 9'd500;
        seg_dt    = 4'(temperature - 9'sd45);
      end else if (temperature <= 9'sd65) begin
        seg_base  = 16'd17000;
        seg_slope = 9'd400;
        seg_dt    = 4'(temperature - 9'sd55);
      end else if (temperature <= 9'sd75) begin
        seg_tail = 1'b1;
        seg_dt   = 4'(temperature - 9'sd65);
      end else begin
        seg_top = 1'b1;
      end
    end
  end

  always_comb begin
    fixed_val = 17'(seg_base) + 17'({4'd0, seg_slope} * {9'd0, seg_dt});

    // span * dt / width, truncated toward zero, as quo*dt + rem*dt/width
    if (!is_sport) begin
      tail_neg       = tq_neg_r;
      tail_base      = QUIET_TAIL_BASE;
      tail_whole     = 18'(tq_quo_r) * 18'(seg_dt);
      tail_rd        = 7'(tq_rem_r) * 7'(seg_dt);
      tail_frac_prod = 16'(tail_rd) * 16'd13;
      tail_frac      = 7'(tail_frac_prod >> 6);
    end else begin
      tail_neg       = ts_neg_r;
      tail_base      = SPORT_TAIL_BASE;
      tail_whole     = 18'(ts_quo_r) * 18'(seg_dt);
      tail_rd        = 7'(ts_rem_r) * 7'(seg_dt);
      tail_frac_prod = 16'(tail_rd) * 16'd205;
      tail_frac      = 7'(tail_frac_prod >> 11);
    end
    tail_mag = tail_whole + 18'(tail_frac);
    tail_val = tail_neg ? 20'(tail_base) - 20'(tail_mag) : 20'(tail_base) + 20'(tail_mag);

    if (seg_top) begin
      raw = 20'(safe_max_duty);
    end else if (seg_tail) begin
      raw = tail_val;
    end else begin
      raw = 20'(fixed_val);
    end

    if (raw < 20'sd0) begin
      duty = '0;
    end else if (raw > $signed(20'(safe_max_duty))) begin
      duty = safe_max_duty;
    end else begin
      duty = raw[15:0];
    end
  end

endmodule

// ===== design/fdct_tracker.sv =====
// ----------------------------------------------------------------------------
// fdct_tracker
// Hysteresis and debounce tracker for the curve modes. Next state and the
// reported status are formed in one pass; state moves on each beat that steps with curve_ok.
// ----------------------------------------------------------------------------
module fdct_tracker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fdct_pkg::fdct_cfg_t   cfg,
  input  logic                  step,
  input  logic                  curve_ok,
  input  logic [2:0]            mode,
  input  logic signed [8:0]     temperature,
  input  logic [15:0]           target,
  output fdct_pkg::fdct_track_t stat
);

  logic                primed_r, primed_nxt;
  logic [2:0]          mode_r, mode_nxt;
  logic signed [8:0]   acc_temp_r, acc_temp_nxt;
  logic [15:0]         duty_r, duty_nxt;
  fdct_pkg::fdct_dir_t dir_r, dir_nxt;
  logic [3:0]          cnt_r, cnt_nxt;

  logic                changed;
  logic signed [9:0]   delta;
  logic [9:0]          delta_mag;
  fdct_pkg::fdct_dir_t new_dir;
  logic [3:0]          cnt_try;
  logic signed [8:0]   high_temp;

  always_comb begin
    high_temp    = cfg.high_temp;
    primed_nxt   = primed_r;
    mode_nxt     = mode_r;
    acc_temp_nxt = acc_temp_r;
    duty_nxt     = duty_r;
    dir_nxt      = dir_r;
    cnt_nxt      = cnt_r;
    changed      = 1'b0;
    delta        = 10'(temperature) - 10'(acc_temp_r);
    delta_mag    = delta[9] ? 10'(-delta) : 10'(delta);
    new_dir      = (delta > 10'sd0) ? fdct_pkg::DIR_UP : fdct_pkg::DIR_DOWN;
    if (new_dir != dir_r) begin
      cnt_try = 4'd1;
    end else if (cnt_r != 4'd15) begin
      cnt_try = cnt_r + 4'd1;
    end else begin
      cnt_try = cnt_r;
    end

    if (!primed_r || mode_r != mode) begin
      primed_nxt   = 1'b1;
      mode_nxt     = mode;
      acc_temp_nxt = temperature;
      duty_nxt     = target;
      dir_nxt      = fdct_pkg::DIR_NONE;
      cnt_nxt      = '0;
      changed      = 1'b1;
    end else if (temperature >= high_temp) begin
      acc_temp_nxt = temperature;
      dir_nxt      = fdct_pkg::DIR_NONE;
      cnt_nxt      = '0;
      changed      = duty_r != cfg.safe_max_duty;
      duty_nxt     = cfg.safe_max_duty;
    end else if (delta_mag < 10'(cfg.hysteresis_deg)) begin
      dir_nxt = fdct_pkg::DIR_NONE;
      cnt_nxt = '0;
    end else if (cnt_try >= cfg.debounce_count) begin
      acc_temp_nxt = temperature;
      dir_nxt      = fdct_pkg::DIR_NONE;
      cnt_nxt      = '0;
      changed      = duty_r != target;
      duty_nxt     = target;
    end else begin
      dir_nxt = new_dir;
      cnt_nxt = cnt_try;
    end

    stat.valid   = curve_ok;
    stat.changed = curve_ok & changed;
    stat.duty    = curve_ok ? duty_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r   <= 1'b0;
      mode_r     <= fdct_pkg::MODE_OFF;
      acc_temp_r <= '0;
      duty_r     <= '0;
      dir_r      <= fdct_pkg::DIR_NONE;
      cnt_r      <= '0;
    end else if (step && curve_ok) begin
      primed_r   <= primed_nxt;
      mode_r     <= mode_nxt;
      acc_temp_r <= acc_temp_nxt;
      duty_r     <= duty_nxt;
      dir_r      <= dir_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule

// ===== design/fan_duty_curve_tracker.sv =====
// ----------------------------------------------------------------------------
// fan_duty_curve_tracker
// Per-sample fan duty policy (off, disabled, quiet, sport, custom, smart)
// plus a hysteresis/debounce tracker that follows the quiet and sport curves.
//
//   channel  ports                                     beat
//   in       in_valid/in_ready, mode, temp, duty       one sample
//   out      out_valid/out_ready, policy and curve     one result per sample
//   cfg      cfg_we, cfg_index, cfg_wdata              one register write
//
// Three register stages: input, policy/tracker, custom quantize/output.
// One sample per cycle sustained while out_ready stays high.
// Tracker state is updated in the second stage, so back-to-back samples
// see each other's effect. Each stage holds on a stall and bubbles collapse.
// Synchronous active-low reset clears tracker, valids and config to defaults.
// ----------------------------------------------------------------------------
module fan_duty_curve_tracker #(
  parameter int unsigned CUSTOM_STEP = 1000
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_fan_mode,
  input  logic signed [8:0]  in_temperature,
  input  logic [15:0]        in_custom_duty,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_policy_valid,
  output logic [15:0]        out_policy_duty,
  output logic               out_curve_valid,
  output logic               out_curve_changed,
  output logic [15:0]        out_curve_duty,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam logic [15:0] STEP16      = 16'(CUSTOM_STEP);
  localparam logic [63:0] RECIP_FULL  =
    ((64'd1 << 32) + 64'(CUSTOM_STEP) - 64'd1) / 64'(CUSTOM_STEP);
  localparam logic [31:0] CUST_RECIP  = (CUSTOM_STEP == 1) ? 32'd0 : RECIP_FULL[31:0];

  // config registers
  fdct_pkg::fdct_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.safe_max_duty   <= 16'd25000;
      cfg_r.min_temp        <= 9'sd0;
      cfg_r.max_temp        <= 9'sd125;
      cfg_r.high_temp       <= 9'sd90;
      cfg_r.hysteresis_deg  <= 8'd2;
      cfg_r.debounce_count  <= 4'd3;
      cfg_r.custom_min_duty <= 16'd5000;
      cfg_r.custom_max_duty <= 16'd25000;
    end else if (cfg_we) begin
      case (cfg_index)
        fdct_pkg::CFG_SAFE_MAX_DUTY:   cfg_r.safe_max_duty   <= cfg_wdata;
        fdct_pkg::CFG_MIN_TEMP:        cfg_r.min_temp        <= cfg_wdata[8:0];
        fdct_pkg::CFG_MAX_TEMP:        cfg_r.max_temp        <= cfg_wdata[8:0];
        fdct_pkg::CFG_HIGH_TEMP:       cfg_r.high_temp       <= cfg_wdata[8:0];
        fdct_pkg::CFG_HYSTERESIS_DEG:  cfg_r.hysteresis_deg  <= cfg_wdata[7:0];
        fdct_pkg::CFG_DEBOUNCE_COUNT:  cfg_r.debounce_count  <= cfg_wdata[3:0];
        fdct_pkg::CFG_CUSTOM_MIN_DUTY: cfg_r.custom_min_duty <= cfg_wdata;
        fdct_pkg::CFG_CUSTOM_MAX_DUTY: cfg_r.custom_max_duty <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage handshake
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_rdy, s2_rdy, s1_go;

  assign out_rdy  = !out_v_r || out_ready;
  assign s2_rdy   = !s2_v_r || out_rdy;
  assign s1_go    = s1_v_r && s2_rdy;
  assign in_ready = !s1_v_r || s2_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (out_rdy) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // input register
  logic [2:0]        s1_mode_r;
  logic signed [8:0] s1_temp_r;
  logic [15:0]       s1_cduty_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r  <= in_fan_mode;
      s1_temp_r  <= in_temperature;
      s1_cduty_r <= in_custom_duty;
    end
  end

  // policy and tracker pass
  logic signed [8:0] min_temp, max_temp;
  logic              temp_ok;
  logic              is_curve, is_custom;
  logic [15:0]       curve_target;
  logic              curve_ok;
  logic [6:0]        smart_t;
  logic [13:0]       smart_x;
  logic [15:0]       smart_x5;
  logic [15:0]       smart_duty;
  logic              pv;
  logic [15:0]       pd;
  logic [15:0]       cust_c;
  logic              cust_neg;
  logic [15:0]       cust_mag;
  logic [47:0]       cust_prod;
  logic [15:0]       cust_quo;
  fdct_pkg::fdct_track_t trk;

  fdct_curve u_curve (
    .clk           (clk),
    .safe_max_duty (cfg_r.safe_max_duty),
    .is_sport      (s1_mode_r == fdct_pkg::MODE_SPORT),
    .temperature   (s1_temp_r),
    .duty          (curve_target)
  );

  assign min_temp  = cfg_r.min_temp;
  assign max_temp  = cfg_r.max_temp;
  assign temp_ok   = (s1_temp_r >= min_temp) && (s1_temp_r <= max_temp);
  assign is_curve  = (s1_mode_r == fdct_pkg::MODE_QUIET) || (s1_mode_r == fdct_pkg::MODE_SPORT);
  assign is_custom = s1_mode_r == fdct_pkg::MODE_CUSTOM;
  assign curve_ok  = is_curve && temp_ok;

  fdct_tracker u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .step        (s1_go),
    .curve_ok    (curve_ok),
    .mode        (s1_mode_r),
    .temperature (s1_temp_r),
    .target      (curve_target),
    .stat        (trk)
  );

  always_comb begin
    smart_t  = s1_temp_r[6:0];
    smart_x  = 14'(smart_t) * 14'd151 - 14'd2800;
    smart_x5 = {smart_x, 2'b00} + {2'b00, smart_x};
    if (s1_temp_r < 9'sd5) begin
      smart_duty = '0;
    end else if (s1_temp_r < 9'sd40) begin
      smart_duty = 16'd8000;
    end else if (s1_temp_r < 9'sd85) begin
      smart_duty = {1'b0, smart_x5[15:1]};
    end else begin
      smart_duty = cfg_r.safe_max_duty;
    end

    // custom clamp, then distance from the minimum over the step
    if (s1_cduty_r < cfg_r.custom_min_duty) begin
      cust_c = cfg_r.custom_min_duty;
    end else if (s1_cduty_r > cfg_r.custom_max_duty) begin
      cust_c = cfg_r.custom_max_duty;
    end else begin
      cust_c = s1_cduty_r;
    end
    cust_neg  = cust_c < cfg_r.custom_min_duty;
    cust_mag  = cust_neg ? cfg_r.custom_min_duty - cust_c : cust_c - cfg_r.custom_min_duty;
    cust_prod = 48'(cust_mag) * 48'(CUST_RECIP);
    cust_quo  = (CUSTOM_STEP == 1) ? cust_mag : cust_prod[47:32];

    pv = 1'b0;
    pd = '0;
    case (s1_mode_r)
      fdct_pkg::MODE_DISABLED: begin
        pv = 1'b1;
      end
      fdct_pkg::MODE_QUIET, fdct_pkg::MODE_SPORT: begin
        pv = temp_ok;
        pd = curve_target;
      end
      fdct_pkg::MODE_CUSTOM: begin
        pv = 1'b1;
      end
      fdct_pkg::MODE_SMART: begin
        pv = temp_ok;
        pd = smart_duty;
      end
      default: ;
    endcase
    if (!is_custom && s1_cduty_r != 16'd0) begin
      pv = 1'b0;
    end
    if (!pv) begin
      pd = '0;
    end
  end

  logic                  s2_pv_r;
  logic [15:0]           s2_pd_r;
  logic                  s2_cust_r;
  logic                  s2_cneg_r;
  logic [15:0]           s2_cquo_r;
  fdct_pkg::fdct_track_t s2_trk_r;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_pv_r   <= pv;
      s2_pd_r   <= pd;
      s2_cust_r <= is_custom;
      s2_cneg_r <= cust_neg;
      s2_cquo_r <= cust_quo;
      s2_trk_r  <= trk;
    end
  end

  // custom quantize and result register
  logic [31:0] cust_span;
  logic [15:0] cust_duty;
  logic [15:0] pd_final;

  always_comb begin
    cust_span = 32'(s2_cquo_r) * 32'(STEP16);
    cust_duty = s2_cneg_r ? cfg_r.custom_min_duty - cust_span[15:0]
                          : cfg_r.custom_min_duty + cust_span[15:0];
    pd_final  = s2_cust_r ? cust_duty : s2_pd_r;
  end

  logic        out_pv_r;
  logic [15:0] out_pd_r;
  logic        out_cv_r;
  logic        out_cc_r;
  logic [15:0] out_cd_r;

  always_ff @(posedge clk) begin
    if (s2_v_r && out_rdy) begin
      out_pv_r <= s2_pv_r;
      out_pd_r <= pd_final;
      out_cv_r <= s2_trk_r.valid;
      out_cc_r <= s2_trk_r.changed;
      out_cd_r <= s2_trk_r.duty;
    end
  end

  assign out_valid         = out_v_r;
  assign out_policy_valid  = out_pv_r;
  assign out_policy_duty   = out_pd_r;
  assign out_curve_valid   = out_cv_r;
  assign out_curve_changed = out_cc_r;
  assign out_curve_duty    = out_cd_r;

`ifndef ASSERT_OFF
  a_changed_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_curve_changed || out_curve_valid))
    else $error("curve_changed without curve_valid");

  a_policy_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_policy_valid) |-> (out_policy_duty == 16'd0))
    else $error("nonzero policy duty on invalid result");

  a_curve_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_curve_valid) |-> (out_curve_duty == 16'd0))
    else $error("nonzero curve duty on invalid curve");

  a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !out_rdy) |=> s2_v_r)
    else $error("stage two beat dropped under stall");
`endif

endmodule
